// File: hw/rtl/rls_pkg.sv
// Shared constants, types and helper functions for the recurrence line statistics core.
package rls_pkg;

    localparam int MAX_SIZE    = 1024;
    localparam int POS_W       = $clog2(MAX_SIZE);
    localparam int SIZE_W      = POS_W + 1;
    localparam int NDIAG       = 2 * MAX_SIZE - 1;
    localparam int DIAG_AW     = $clog2(NDIAG);

    localparam int CFG_W       = 11;
    localparam int WIN_W       = 10;
    localparam int RUN_W       = 11;
    localparam int ACC_W       = 21;
    localparam int REG_IDX_W   = 2;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [REG_IDX_W-1:0] REG_MATRIX_SIZE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_DIAG    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_VERT    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_THEILER     = 2'd3;

    typedef struct packed {
        logic               rec;
        logic               kept;
        logic [POS_W-1:0]   col_addr;
        logic [DIAG_AW-1:0] diag_addr;
        logic               diag_first;
        logic               diag_last;
        logic               col_first;
        logic               col_last;
        logic               mat_end;
    } cell_t;

    typedef struct packed {
        logic [CFG_W-1:0] min_diag;
        logic [CFG_W-1:0] min_vert;
    } len_cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0] raw_points;
        logic [ACC_W-1:0] kept_points;
        logic [ACC_W-1:0] diag_line_count;
        logic [ACC_W-1:0] diag_line_points;
        logic [RUN_W-1:0] diag_line_max;
        logic [ACC_W-1:0] vert_line_count;
        logic [ACC_W-1:0] vert_line_points;
        logic [RUN_W-1:0] vert_line_max;
    } result_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        if (int'(v) < 2) begin
            return SIZE_W'(2);
        end else if (int'(v) > MAX_SIZE) begin
            return SIZE_W'(MAX_SIZE);
        end
        return SIZE_W'(v);
    endfunction

    function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] r);
        return (r == RUN_MAX) ? r : r + RUN_W'(1);
    endfunction

    function automatic logic [ACC_W-1:0] acc_add(input logic [ACC_W-1:0] a,
                                                 input logic [RUN_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + (ACC_W+1)'(b);
        return (s > {1'b0, ACC_MAX}) ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    function automatic logic line_hit(input logic [RUN_W-1:0] run, input logic close,
                                      input logic [CFG_W-1:0] minlen);
        logic [CFG_W-1:0] m;
        m = (minlen == '0) ? CFG_W'(1) : minlen;
        return close && (run != '0) && (CFG_W'(run) >= m);
    endfunction

endpackage

// File: hw/rtl/recurrence_line_statistics_core.sv
// Top level of the recurrence line statistics core: configuration registers and block wiring.
// Streams a square binary recurrence matrix one cell per word in row-major order and,
// after the final cell, presents one word with the raw and kept point counts and the
// count, length sum and maximum of diagonal and vertical lines. Sustained rate is one
// cell per clock unless a final cell waits for an untaken result word; it is set by the
// single read-modify-write of the diagonal and column run memories per cell. The result
// is registered after the final cell passes the queue and the run memory read. No clearing
// pass is needed after reset: a run read at the start of its diagonal or column is forced to
// zero. Writing matrix_size restarts the matrix; write registers only while the core is idle.
module recurrence_line_statistics_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rls_pkg::REG_IDX_W-1:0]  cfg_addr,
    input  logic [rls_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_recurrent,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rls_pkg::ACC_W-1:0]      m_raw_points,
    output logic [rls_pkg::ACC_W-1:0]      m_kept_points,
    output logic [rls_pkg::ACC_W-1:0]      m_diag_line_count,
    output logic [rls_pkg::ACC_W-1:0]      m_diag_line_points,
    output logic [rls_pkg::RUN_W-1:0]      m_diag_line_max,
    output logic [rls_pkg::ACC_W-1:0]      m_vert_line_count,
    output logic [rls_pkg::ACC_W-1:0]      m_vert_line_points,
    output logic [rls_pkg::RUN_W-1:0]      m_vert_line_max
);
    import rls_pkg::*;

    logic [CFG_W-1:0] matrix_size_reg;
    logic [CFG_W-1:0] min_diag_reg;
    logic [CFG_W-1:0] min_vert_reg;
    logic [WIN_W-1:0] theiler_reg;
    logic             size_clear;
    len_cfg_t         len_cfg;

    logic             push_valid, push_ready;
    cell_t            push_data;
    logic             pop_valid, pop_ready;
    cell_t            pop_data;
    logic             at_origin;
    logic             end_fire;
    result_t          result;

    assign size_clear       = cfg_wr_en && (cfg_addr == REG_MATRIX_SIZE);
    assign len_cfg.min_diag = min_diag_reg;
    assign len_cfg.min_vert = min_vert_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            matrix_size_reg <= CFG_W'(1024);
            min_diag_reg    <= CFG_W'(2);
            min_vert_reg    <= CFG_W'(2);
            theiler_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MATRIX_SIZE: matrix_size_reg <= cfg_wdata;
                REG_MIN_DIAG:    min_diag_reg    <= cfg_wdata;
                REG_MIN_VERT:    min_vert_reg    <= cfg_wdata;
                REG_THEILER:     theiler_reg     <= cfg_wdata[WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rls_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (size_clear),
        .size        (eff_size(matrix_size_reg)),
        .window      (theiler_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_recurrent (s_recurrent),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data),
        .at_origin   (at_origin)
    );

    rls_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rls_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (size_clear),
        .len_cfg   (len_cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (result),
        .end_fire  (end_fire)
    );

    assign m_raw_points       = result.raw_points;
    assign m_kept_points      = result.kept_points;
    assign m_diag_line_count  = result.diag_line_count;
    assign m_diag_line_points = result.diag_line_points;
    assign m_diag_line_max    = result.diag_line_max;
    assign m_vert_line_count  = result.vert_line_count;
    assign m_vert_line_points = result.vert_line_points;
    assign m_vert_line_max    = result.vert_line_max;

`ifndef SYNTHESIS
    a_wrap_to_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_valid && push_ready && push_data.mat_end) |=> at_origin)
        else $error("front did not wrap to the first cell after the final cell");

    a_end_gives_word: assert property (@(posedge aclk) disable iff (!aresetn)
        end_fire |=> m_valid)
        else $error("final cell left the back end without a result word");

    a_kept_le_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kept_points <= m_raw_points))
        else $error("kept points exceed raw points");

    a_diag_sum_ge_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_diag_line_points >= m_diag_line_count))
        else $error("diagonal line points below line count");
`endif

endmodule

// File: hw/rtl/rls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/rls_front.sv
// Front end: cell position counters, window blanking and run addressing.
module rls_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic [rls_pkg::SIZE_W-1:0]  size,
    input  logic [rls_pkg::WIN_W-1:0]   window,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_recurrent,
    output logic                        push_valid,
    input  logic                        push_ready,
    output rls_pkg::cell_t              push_data,
    output logic                        at_origin
);
    import rls_pkg::*;

    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic             last_row;
    logic             last_col;
    logic [POS_W-1:0] gap;
    logic [WIN_W-1:0] win;
    logic             kept;

    always_comb begin
        last_row = ({1'b0, row_reg} + SIZE_W'(1)) >= size;
        last_col = ({1'b0, col_reg} + SIZE_W'(1)) >= size;
        gap      = (col_reg >= row_reg) ? col_reg - row_reg : row_reg - col_reg;
        win      = (window == '0) ? WIN_W'(1) : window;
        kept     = s_recurrent && (int'(gap) >= int'(win));

        push_data.rec        = s_recurrent;
        push_data.kept       = kept;
        push_data.col_addr   = col_reg;
        push_data.diag_addr  = DIAG_AW'(col_reg) + DIAG_AW'(MAX_SIZE - 1) - DIAG_AW'(row_reg);
        push_data.diag_first = (row_reg == '0) || (col_reg == '0);
        push_data.diag_last  = last_row || last_col;
        push_data.col_first  = (row_reg == '0);
        push_data.col_last   = last_row;
        push_data.mat_end    = last_row && last_col;

        col_next = last_col ? '0 : col_reg + POS_W'(1);
        row_next = row_reg;
        if (last_col) begin
            row_next = last_row ? '0 : row_reg + POS_W'(1);
        end
    end

    assign push_valid = s_valid;
    assign s_ready    = push_ready;
    assign at_origin  = (row_reg == '0) && (col_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (s_valid && push_ready) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// File: hw/rtl/rls_fifo.sv
// Short queue of classified cells between the front end and the back end.
module rls_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  rls_pkg::cell_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rls_pkg::cell_t pop_data
);
    import rls_pkg::*;

    cell_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/rls_back.sv
// Back end: run memories, line detection, accumulators and result register.
module rls_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  rls_pkg::len_cfg_t len_cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  rls_pkg::cell_t    pop_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rls_pkg::result_t  result,
    output logic              end_fire
);
    import rls_pkg::*;

    logic             s1_valid_reg;
    cell_t            s1_cell_reg;
    logic             s1_fire;
    logic             load;
    logic             out_valid_reg;
    result_t          result_reg;
    result_t          acc_reg, acc_next;

    logic [RUN_W-1:0] diag_rd, diag_old, diag_new, diag_wr;
    logic [RUN_W-1:0] col_rd, col_old, col_new, col_wr;
    logic             diag_close, diag_line;
    logic             col_close, col_line;

    assign s1_fire   = s1_valid_reg && (!s1_cell_reg.mat_end || !out_valid_reg || m_ready);
    assign pop_ready = !s1_valid_reg || s1_fire;
    assign load      = pop_valid && pop_ready;
    assign end_fire  = s1_fire && s1_cell_reg.mat_end;

    rls_ram #(.WIDTH(RUN_W), .DEPTH(NDIAG)) u_diag_ram (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_cell_reg.diag_addr),
        .wr_data (diag_wr),
        .rd_en   (load),
        .rd_addr (pop_data.diag_addr),
        .rd_data (diag_rd)
    );

    rls_ram #(.WIDTH(RUN_W), .DEPTH(MAX_SIZE)) u_col_ram (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_cell_reg.col_addr),
        .wr_data (col_wr),
        .rd_en   (load),
        .rd_addr (pop_data.col_addr),
        .rd_data (col_rd)
    );

    always_comb begin
        diag_old   = s1_cell_reg.diag_first ? '0 : diag_rd;
        diag_new   = s1_cell_reg.kept ? run_inc(diag_old) : diag_old;
        diag_close = !s1_cell_reg.kept || s1_cell_reg.diag_last;
        diag_wr    = diag_close ? '0 : diag_new;
        diag_line  = line_hit(diag_new, diag_close, len_cfg.min_diag);

        col_old    = s1_cell_reg.col_first ? '0 : col_rd;
        col_new    = s1_cell_reg.kept ? run_inc(col_old) : col_old;
        col_close  = !s1_cell_reg.kept || s1_cell_reg.col_last;
        col_wr     = col_close ? '0 : col_new;
        col_line   = line_hit(col_new, col_close, len_cfg.min_vert);

        acc_next = acc_reg;
        if (s1_cell_reg.rec) begin
            acc_next.raw_points = acc_add(acc_reg.raw_points, RUN_W'(1));
        end
        if (s1_cell_reg.kept) begin
            acc_next.kept_points = acc_add(acc_reg.kept_points, RUN_W'(1));
        end
        if (diag_line) begin
            acc_next.diag_line_count  = acc_add(acc_reg.diag_line_count, RUN_W'(1));
            acc_next.diag_line_points = acc_add(acc_reg.diag_line_points, diag_new);
            if (diag_new > acc_reg.diag_line_max) begin
                acc_next.diag_line_max = diag_new;
            end
        end
        if (col_line) begin
            acc_next.vert_line_count  = acc_add(acc_reg.vert_line_count, RUN_W'(1));
            acc_next.vert_line_points = acc_add(acc_reg.vert_line_points, col_new);
            if (col_new > acc_reg.vert_line_max) begin
                acc_next.vert_line_max = col_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end else begin
            if (pop_ready) begin
                s1_valid_reg <= pop_valid;
            end
            if (clear || end_fire) begin
                acc_reg <= '0;
            end else if (s1_fire) begin
                acc_reg <= acc_next;
            end
            if (end_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_cell_reg <= pop_data;
        end
        if (end_fire) begin
            result_reg <= acc_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = result_reg;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the recurrence line statistics core.
module testbench;
    import rls_pkg::*;

    localparam int SETTLE = 8;
    localparam logic [3:0] ALL_REGS  = 4'b1111;
    localparam logic [3:0] SIZE_ONLY = 4'(1 << REG_MATRIX_SIZE);
    localparam logic [3:0] LEN_WIN   = ALL_REGS & ~SIZE_ONLY;

    typedef struct {
        logic [CFG_W-1:0] size_w;
        logic [CFG_W-1:0] diag_w;
        logic [CFG_W-1:0] vert_w;
        logic [CFG_W-1:0] win_w;
        logic [15:0]      cells;
        logic             typed;
        result_t          want;
    } matrix_row_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [REG_IDX_W-1:0] cfg_addr    = '0;
    logic [CFG_W-1:0]     cfg_wdata   = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_recurrent = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [ACC_W-1:0]     m_raw_points;
    logic [ACC_W-1:0]     m_kept_points;
    logic [ACC_W-1:0]     m_diag_line_count;
    logic [ACC_W-1:0]     m_diag_line_points;
    logic [RUN_W-1:0]     m_diag_line_max;
    logic [ACC_W-1:0]     m_vert_line_count;
    logic [ACC_W-1:0]     m_vert_line_points;
    logic [RUN_W-1:0]     m_vert_line_max;

    logic [CFG_W-1:0] cfg_size;
    logic [CFG_W-1:0] cfg_min_diag;
    logic [CFG_W-1:0] cfg_min_vert;
    logic [WIN_W-1:0] cfg_win;

    logic [RUN_W-1:0] diag_len [NDIAG];
    logic [RUN_W-1:0] col_len [MAX_SIZE];
    logic [POS_W-1:0] row_at;
    logic [POS_W-1:0] col_at;
    logic [ACC_W-1:0] raw_seen;
    logic [ACC_W-1:0] kept_seen;
    logic [ACC_W-1:0] diag_cnt;
    logic [ACC_W-1:0] diag_sum;
    logic [RUN_W-1:0] diag_top;
    logic [ACC_W-1:0] vert_cnt;
    logic [ACC_W-1:0] vert_sum;
    logic [RUN_W-1:0] vert_top;

    result_t     stats_due [$];
    result_t     want;
    matrix_row_t plan [5];

    int src_idle_pct = 31;
    int dst_idle_pct = 71;
    int cells_fed = 0;
    int matrices_closed = 0;
    int reg_writes = 0;
    int mismatches = 0;

    recurrence_line_statistics_core u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_recurrent        (s_recurrent),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_raw_points       (m_raw_points),
        .m_kept_points      (m_kept_points),
        .m_diag_line_count  (m_diag_line_count),
        .m_diag_line_points (m_diag_line_points),
        .m_diag_line_max    (m_diag_line_max),
        .m_vert_line_count  (m_vert_line_count),
        .m_vert_line_points (m_vert_line_points),
        .m_vert_line_max    (m_vert_line_max)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d results still outstanding", stats_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int clamp_size(input logic [CFG_W-1:0] v);
        if (v < 2) return 2;
        if (v > MAX_SIZE) return MAX_SIZE;
        return int'(v);
    endfunction

    function automatic logic [ACC_W-1:0] acc_plus(input logic [ACC_W-1:0] a, input int b);
        int s;
        s = int'(a) + b;
        return (s > int'(ACC_MAX)) ? ACC_MAX : ACC_W'(s);
    endfunction

    function automatic logic [CFG_W-1:0] pick_min(input int n);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'($urandom_range(n + 1, 2047));
            2: return CFG_W'(n);
            3: return CFG_W'(MAX_SIZE);
            default: return CFG_W'($urandom_range(1, (n < 4) ? n : 4));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_window(input int n);
        case ($urandom_range(0, 9))
            0, 1: return '0;
            2: return CFG_W'($urandom_range(0, 2047));
            3: return CFG_W'(MAX_SIZE - 1);
            default: return CFG_W'($urandom_range(1, n));
        endcase
    endfunction

    task automatic clear_tally();
        foreach (diag_len[i]) diag_len[i] = '0;
        foreach (col_len[i]) col_len[i] = '0;
        row_at = '0;
        col_at = '0;
        raw_seen = '0;
        kept_seen = '0;
        diag_cnt = '0;
        diag_sum = '0;
        diag_top = '0;
        vert_cnt = '0;
        vert_sum = '0;
        vert_top = '0;
    endtask

    task automatic step_run(inout logic [RUN_W-1:0] run, input logic kept, input logic at_edge,
                            input logic [CFG_W-1:0] minlen, inout logic [ACC_W-1:0] cnt,
                            inout logic [ACC_W-1:0] sum, inout logic [RUN_W-1:0] longest);
        int need;
        need = (minlen == '0) ? 1 : int'(minlen);
        if (kept) run = (run == RUN_MAX) ? run : run + 1'b1;
        if (!kept || at_edge) begin
            if (run != '0 && int'(run) >= need) begin
                cnt = acc_plus(cnt, 1);
                sum = acc_plus(sum, int'(run));
                if (run > longest) longest = run;
            end
            run = '0;
        end
    endtask

    task automatic tally_cell(input logic rec, output logic done, output result_t stats);
        int n, r, c, win, gap, di;
        logic kept, last_row, last_col;
        logic [RUN_W-1:0] run;
        n = clamp_size(cfg_size);
        r = int'(row_at);
        c = int'(col_at);
        win = (cfg_win == '0) ? 1 : int'(cfg_win);
        gap = (c >= r) ? c - r : r - c;
        kept = rec && (gap >= win);
        di = c + MAX_SIZE - 1 - r;
        last_row = (r + 1 >= n);
        last_col = (c + 1 >= n);
        if (rec) raw_seen = acc_plus(raw_seen, 1);
        if (kept) kept_seen = acc_plus(kept_seen, 1);
        run = diag_len[di];
        step_run(run, kept, last_row || last_col, cfg_min_diag, diag_cnt, diag_sum, diag_top);
        diag_len[di] = run;
        run = col_len[c];
        step_run(run, kept, last_row, cfg_min_vert, vert_cnt, vert_sum, vert_top);
        col_len[c] = run;
        done = 1'b0;
        stats = '0;
        if (!last_col) begin
            col_at = col_at + 1'b1;
        end else begin
            col_at = '0;
            if (!last_row) begin
                row_at = row_at + 1'b1;
            end else begin
                done = 1'b1;
                stats = '{raw_seen, kept_seen, diag_cnt, diag_sum, diag_top,
                          vert_cnt, vert_sum, vert_top};
                clear_tally();
            end
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (stats_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_MATRIX_SIZE: begin
                cfg_size = val;
                clear_tally();
            end
            REG_MIN_DIAG: cfg_min_diag = val;
            REG_MIN_VERT: cfg_min_vert = val;
            REG_THEILER:  cfg_win = val[WIN_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_config(input logic [3:0] which, input logic [CFG_W-1:0] v_size,
                                input logic [CFG_W-1:0] v_diag, input logic [CFG_W-1:0] v_vert,
                                input logic [CFG_W-1:0] v_win);
        wait_idle();
        if (which[REG_MATRIX_SIZE]) set_reg(REG_MATRIX_SIZE, v_size);
        if (which[REG_MIN_DIAG]) set_reg(REG_MIN_DIAG, v_diag);
        if (which[REG_MIN_VERT]) set_reg(REG_MIN_VERT, v_vert);
        if (which[REG_THEILER]) set_reg(REG_THEILER, v_win);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_cell(input logic rec, input logic typed, input result_t typed_stats);
        logic done;
        result_t stats;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            s_recurrent <= 1'($urandom);
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_recurrent <= rec;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tally_cell(rec, done, stats);
        cells_fed++;
        if (done) begin
            stats_due.push_back(typed ? typed_stats : stats);
        end
    endtask

    task automatic random_matrix();
        int n, dens, tweak_at;
        logic [3:0] which;
        logic [CFG_W-1:0] v_size, v_diag, v_vert, v_win;
        which = ($urandom_range(0, 1) == 0) ? 4'($urandom) : 4'b0000;
        case ($urandom_range(0, 9))
            0: v_size = CFG_W'($urandom_range(0, 1));
            1: v_size = CFG_W'($urandom_range(7, 14));
            default: v_size = CFG_W'($urandom_range(2, 6));
        endcase
        n = which[REG_MATRIX_SIZE] ? clamp_size(v_size) : clamp_size(cfg_size);
        v_diag = pick_min(n);
        v_vert = pick_min(n);
        v_win = pick_window(n);
        if (which != 4'b0000) apply_config(which, v_size, v_diag, v_vert, v_win);
        n = clamp_size(cfg_size);
        // abandon a partial matrix, then restart it with a size write
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, n * n - 1)) send_cell(1'($urandom), 1'b0, '0);
            apply_config(SIZE_ONLY, cfg_size, '0, '0, '0);
        end
        dens = 25 * $urandom_range(0, 4);
        tweak_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n * n - 1) : -1;
        for (int j = 0; j < n * n; j++) begin
            if (j == tweak_at) apply_config(LEN_WIN, '0, pick_min(n), pick_min(n), pick_window(n));
            send_cell(1'($urandom_range(0, 99) < dens), 1'b0, '0);
        end
    endtask

    task automatic check_field(input string name, input logic [ACC_W-1:0] exp_v,
                               input logic [ACC_W-1:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in matrix %0d: %s expected %0d got %0d",
                         matrices_closed, name, exp_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (stats_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word, raw_points %0d", m_raw_points);
                end else begin
                    want = stats_due.pop_front();
                    check_field("raw_points", want.raw_points, m_raw_points);
                    check_field("kept_points", want.kept_points, m_kept_points);
                    check_field("diag_line_count", want.diag_line_count, m_diag_line_count);
                    check_field("diag_line_points", want.diag_line_points, m_diag_line_points);
                    check_field("diag_line_max", ACC_W'(want.diag_line_max),
                                ACC_W'(m_diag_line_max));
                    check_field("vert_line_count", want.vert_line_count, m_vert_line_count);
                    check_field("vert_line_points", want.vert_line_points, m_vert_line_points);
                    check_field("vert_line_max", ACC_W'(want.vert_line_max),
                                ACC_W'(m_vert_line_max));
                end
                matrices_closed++;
            end
            m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    initial begin
        int n;
        plan[0] = '{11'd2, 11'd2, 11'd2, 11'd0, 16'h000F, 1'b1,
                    '{21'd4, 21'd2, 21'd0, 21'd0, 11'd0, 21'd0, 21'd0, 11'd0}};
        plan[1] = '{11'd2, 11'd1, 11'd1, 11'd0, 16'h000F, 1'b1,
                    '{21'd4, 21'd2, 21'd2, 21'd2, 11'd1, 21'd2, 21'd2, 11'd1}};
        plan[2] = '{11'd0, 11'd0, 11'd0, 11'd1023, 16'h000F, 1'b1,
                    '{21'd4, 21'd0, 21'd0, 21'd0, 11'd0, 21'd0, 21'd0, 11'd0}};
        plan[3] = '{11'd3, 11'd1, 11'd2, 11'd0, 16'h01FF, 1'b1,
                    '{21'd9, 21'd6, 21'd4, 21'd6, 11'd2, 21'd2, 21'd4, 11'd2}};
        plan[4] = '{11'd2, 11'd2047, 11'd1, 11'd0, 16'h0006, 1'b0, '0};

        cfg_size = CFG_W'(MAX_SIZE);
        cfg_min_diag = CFG_W'(2);
        cfg_min_vert = CFG_W'(2);
        cfg_win = '0;
        clear_tally();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < 5; k++) begin
            apply_config(ALL_REGS, plan[k].size_w, plan[k].diag_w, plan[k].vert_w,
                         plan[k].win_w);
            n = clamp_size(plan[k].size_w);
            for (int j = 0; j < n * n; j++) send_cell(plan[k].cells[j], plan[k].typed, plan[k].want);
        end

        while (cells_fed < 250) random_matrix();

        src_idle_pct = 71;
        dst_idle_pct = 31;
        while (cells_fed < 450) random_matrix();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        // stream part of the first row of a clamped full-size matrix, then abandon it with a size write
        apply_config(ALL_REGS, 11'd2047, CFG_W'(MAX_SIZE), CFG_W'(MAX_SIZE),
                     CFG_W'($urandom_range(0, MAX_SIZE - 1)));
        repeat (64) send_cell(1'($urandom), 1'b0, '0);
        apply_config(SIZE_ONLY, 11'd4, '0, '0, '0);
        while (cells_fed < 700) random_matrix();

        wait_idle();
        repeat (12) @(posedge aclk);
        $display("run: %0d cells streamed, %0d matrices checked, %0d register writes",
                 cells_fed, matrices_closed, reg_writes);
        $display("run: sizes 2 to 14 under three idling mixes, plus one restarted full-size matrix");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/rls_pkg.sv
hw/rtl/rls_ram.sv
hw/rtl/rls_front.sv
hw/rtl/rls_fifo.sv
hw/rtl/rls_back.sv
hw/rtl/recurrence_line_statistics_core.sv
test/testbench.sv
